// File: rtl/blm_pkg.sv
// Shared constants, types and helpers for the bracket language machine.
// Used by blm_front, blm_back and the top level; depends on nothing else.
package blm_pkg;

	localparam int CODE_DEPTH  = 4096;
	localparam int TAPE_DEPTH  = 4096;
	localparam int STACK_DEPTH = 256;
	localparam int ERROR_DEPTH = 64;
	localparam int INPUT_DEPTH = 16;
	localparam int FQ_DEPTH    = 4;

	localparam int CA_W  = $clog2(CODE_DEPTH);
	localparam int LEN_W = $clog2(CODE_DEPTH + 1);
	localparam int TA_W  = $clog2(TAPE_DEPTH);
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int SH_W  = $clog2(STACK_DEPTH + 1);
	localparam int EA_W  = (ERROR_DEPTH > 1) ? $clog2(ERROR_DEPTH) : 1;
	localparam int EI_W  = $clog2(ERROR_DEPTH + 1);
	localparam int IQ_W  = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
	localparam int QC_W  = $clog2(INPUT_DEPTH + 1);
	localparam int QS_W  = QC_W + 1;
	localparam int FQ_W  = $clog2(FQ_DEPTH);
	localparam int FC_W  = $clog2(FQ_DEPTH + 1);
	localparam int EC_W  = 13;
	localparam int POS_W = 12;
	localparam logic [EC_W-1:0] ERR_SAT = '1;

	// item kinds
	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_FINISH = 3'd1;
	localparam logic [2:0] KIND_QUEUE  = 3'd2;
	localparam logic [2:0] KIND_STEP   = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// command codes
	localparam logic [2:0] CMD_RIGHT = 3'd0;
	localparam logic [2:0] CMD_LEFT  = 3'd1;
	localparam logic [2:0] CMD_INC   = 3'd2;
	localparam logic [2:0] CMD_DEC   = 3'd3;
	localparam logic [2:0] CMD_OUT   = 3'd4;
	localparam logic [2:0] CMD_IN    = 3'd5;
	localparam logic [2:0] CMD_OPEN  = 3'd6;
	localparam logic [2:0] CMD_CLOSE = 3'd7;

	// result status codes
	localparam logic [2:0] STAT_ACCEPT  = 3'd0;
	localparam logic [2:0] STAT_OUTPUT  = 3'd1;
	localparam logic [2:0] STAT_BRACKET = 3'd2;
	localparam logic [2:0] STAT_DONE    = 3'd3;
	localparam logic [2:0] STAT_WAIT    = 3'd4;
	localparam logic [2:0] STAT_OVF     = 3'd5;
	localparam logic [2:0] STAT_REFUSE  = 3'd6;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       is_cmd;
		logic [2:0] code;
	} blm_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       out_byte;
		logic [POS_W-1:0] position;
		logic             last;
	} blm_res_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LDJ_RD, S_LDJ_W2, S_FIN_RD, S_FIN_WR,
		S_FIN_ERD, S_FIN_OUT, S_FIN_OVF, S_EXEC
	} blm_state_t;

	function automatic logic [3:0] cmd_decode(input logic [7:0] b);
		logic [3:0] r;
		case (b)
			8'h3E: r = {1'b1, CMD_RIGHT};
			8'h3C: r = {1'b1, CMD_LEFT};
			8'h2B: r = {1'b1, CMD_INC};
			8'h2D: r = {1'b1, CMD_DEC};
			8'h2E: r = {1'b1, CMD_OUT};
			8'h2C: r = {1'b1, CMD_IN};
			8'h5B: r = {1'b1, CMD_OPEN};
			8'h5D: r = {1'b1, CMD_CLOSE};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/blm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module blm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                          wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                          rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/blm_front.sv
// Front end: takes items off the slave stream, decodes code bytes and
// holds them in a short queue for the back end. Uses blm_pkg.
module blm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        in_kind,
	input  logic [7:0]        in_data,
	output logic              item_valid,
	output blm_pkg::blm_item_t item,
	input  logic              pop
);

	blm_pkg::blm_item_t fq_q [blm_pkg::FQ_DEPTH];
	logic [blm_pkg::FQ_W-1:0] wp_q, rp_q;
	logic [blm_pkg::FC_W-1:0] cnt_q;
	logic [3:0]               dec;
	logic                     push;

	assign in_ready   = (cnt_q != blm_pkg::FC_W'(blm_pkg::FQ_DEPTH));
	assign push       = in_valid && in_ready;
	assign item_valid = (cnt_q != '0);
	assign item       = fq_q[rp_q];
	assign dec        = blm_pkg::cmd_decode(in_data);

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wp_q] <= '{kind: in_kind, data: in_data, is_cmd: dec[3], code: dec[2:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + blm_pkg::FC_W'(push) - blm_pkg::FC_W'(pop);
		end
	end

endmodule

// File: rtl/blm_back.sv
// Back end: loads code, pairs brackets, queues input, reports errors, runs steps.
// Uses blm_pkg and blm_ram for the code, jump, tape, stack and error stores.
module blm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         end_byte,
	input  logic               item_valid,
	input  blm_pkg::blm_item_t item,
	output logic               pop,
	input  logic               res_ready,
	output logic               res_valid,
	output blm_pkg::blm_res_t  res
);

	localparam int CA_W  = blm_pkg::CA_W;
	localparam int LEN_W = blm_pkg::LEN_W;
	localparam int TA_W  = blm_pkg::TA_W;
	localparam int SA_W  = blm_pkg::SA_W;
	localparam int SH_W  = blm_pkg::SH_W;
	localparam int EA_W  = blm_pkg::EA_W;
	localparam int EI_W  = blm_pkg::EI_W;
	localparam int IQ_W  = blm_pkg::IQ_W;
	localparam int QC_W  = blm_pkg::QC_W;
	localparam int QS_W  = blm_pkg::QS_W;
	localparam int EC_W  = blm_pkg::EC_W;

	blm_pkg::blm_state_t state_q, state_d;
	logic [LEN_W-1:0] len_q, len_d, pc_q, pc_d;
	logic [TA_W-1:0]  dp_q, dp_d, clr_q, clr_d;
	logic [SH_W-1:0]  sh_q, sh_d, fi_q, fi_d;
	logic [EC_W-1:0]  ec_q, ec_d;
	logic [EI_W-1:0]  ei_q, ei_d, shown;
	logic [IQ_W-1:0]  qh_q, qh_d;
	logic [QC_W-1:0]  qc_q, qc_d;
	logic             ended_q, ended_d;
	logic [7:0]       qmem_q [blm_pkg::INPUT_DEPTH];
	logic [CA_W-1:0]  at_q, at_d, open_q, open_d;
	logic             out_valid_q;
	blm_pkg::blm_res_t out_q;

	logic              go, emit_ok, emit, load_ok, step_run, ovf;
	blm_pkg::blm_res_t res_d;
	logic              err_add;
	logic [CA_W-1:0]   err_pos;
	logic [QS_W-1:0]   slot_sum;
	logic [IQ_W-1:0]   q_slot;
	logic              q_we;
	logic [7:0]        q_head;

	logic            cmd_we;
	logic [CA_W-1:0] cmd_waddr;
	logic [2:0]      cmd_wdata, cmd_rdata;
	logic            jmp_we;
	logic [CA_W-1:0] jmp_waddr, jmp_wdata, jmp_rdata;
	logic            tape_we;
	logic [TA_W-1:0] tape_waddr;
	logic [7:0]      tape_wdata, tape_rdata;
	logic            stk_we;
	logic [SA_W-1:0] stk_waddr, stk_raddr;
	logic [CA_W-1:0] stk_wdata, stk_rdata;
	logic            err_we;
	logic [EA_W-1:0] err_waddr, err_raddr;
	logic [CA_W-1:0] err_rdata;

	assign emit_ok  = !out_valid_q || res_ready;
	assign go       = (state_q == blm_pkg::S_IDLE) && item_valid && emit_ok;
	assign pop      = go;
	assign load_ok  = item.is_cmd && (len_q < LEN_W'(blm_pkg::CODE_DEPTH));
	assign step_run = (ec_q == '0) && (sh_q == '0) && (pc_q < len_q);
	assign ovf      = ec_q > EC_W'(blm_pkg::ERROR_DEPTH);
	assign shown    = ovf ? EI_W'(blm_pkg::ERROR_DEPTH - 1) : EI_W'(ec_q);
	assign slot_sum = QS_W'(qh_q) + QS_W'(qc_q);
	assign q_slot   = (slot_sum >= QS_W'(blm_pkg::INPUT_DEPTH))
		? IQ_W'(slot_sum - QS_W'(blm_pkg::INPUT_DEPTH)) : IQ_W'(slot_sum);
	assign q_head   = qmem_q[qh_q];
	assign res_valid = out_valid_q;
	assign res       = out_q;

	blm_ram #(.W(3), .D(blm_pkg::CODE_DEPTH)) u_cmd (
		.clk, .we(cmd_we), .waddr(cmd_waddr), .wdata(cmd_wdata),
		.raddr(pc_q[CA_W-1:0]), .rdata(cmd_rdata));
	blm_ram #(.W(CA_W), .D(blm_pkg::CODE_DEPTH)) u_jmp (
		.clk, .we(jmp_we), .waddr(jmp_waddr), .wdata(jmp_wdata),
		.raddr(pc_q[CA_W-1:0]), .rdata(jmp_rdata));
	blm_ram #(.W(8), .D(blm_pkg::TAPE_DEPTH)) u_tape (
		.clk, .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
		.raddr(dp_q), .rdata(tape_rdata));
	blm_ram #(.W(CA_W), .D(blm_pkg::STACK_DEPTH)) u_stk (
		.clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata));
	blm_ram #(.W(CA_W), .D(blm_pkg::ERROR_DEPTH)) u_err (
		.clk, .we(err_we), .waddr(err_waddr), .wdata(err_pos),
		.raddr(err_raddr), .rdata(err_rdata));

	always_comb begin
		state_d = state_q;
		case (state_q)
			blm_pkg::S_CLR: begin
				if (clr_q == TA_W'(blm_pkg::TAPE_DEPTH - 1)) state_d = blm_pkg::S_IDLE;
			end
			blm_pkg::S_IDLE: begin
				if (go) begin
					case (item.kind)
						blm_pkg::KIND_LOAD: begin
							if (load_ok && item.code == blm_pkg::CMD_CLOSE && sh_q != '0)
								state_d = blm_pkg::S_LDJ_RD;
						end
						blm_pkg::KIND_FINISH: state_d = blm_pkg::S_FIN_RD;
						blm_pkg::KIND_STEP: begin
							if (step_run) state_d = blm_pkg::S_EXEC;
						end
						blm_pkg::KIND_CLEAR: state_d = blm_pkg::S_CLR;
						default: state_d = blm_pkg::S_IDLE;
					endcase
				end
			end
			blm_pkg::S_LDJ_RD: state_d = blm_pkg::S_LDJ_W2;
			blm_pkg::S_LDJ_W2: state_d = blm_pkg::S_IDLE;
			blm_pkg::S_FIN_RD: begin
				state_d = (fi_q == sh_q) ? blm_pkg::S_FIN_ERD : blm_pkg::S_FIN_WR;
			end
			blm_pkg::S_FIN_WR: state_d = blm_pkg::S_FIN_RD;
			blm_pkg::S_FIN_ERD: begin
				if (ec_q == '0) begin
					if (emit_ok) state_d = blm_pkg::S_IDLE;
				end else if (ei_q == shown) begin
					state_d = ovf ? blm_pkg::S_FIN_OVF : blm_pkg::S_IDLE;
				end else begin
					state_d = blm_pkg::S_FIN_OUT;
				end
			end
			blm_pkg::S_FIN_OUT: begin
				if (emit_ok) state_d = blm_pkg::S_FIN_ERD;
			end
			blm_pkg::S_FIN_OVF: begin
				if (emit_ok) state_d = blm_pkg::S_IDLE;
			end
			blm_pkg::S_EXEC: state_d = blm_pkg::S_IDLE;
			default: state_d = blm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		len_d = len_q; pc_d = pc_q; dp_d = dp_q; clr_d = clr_q;
		sh_d = sh_q; fi_d = fi_q; ec_d = ec_q; ei_d = ei_q;
		qh_d = qh_q; qc_d = qc_q; ended_d = ended_q;
		at_d = at_q; open_d = open_q;
		emit = 1'b0;
		res_d = '{status: blm_pkg::STAT_ACCEPT, out_byte: 8'd0, position: '0, last: 1'b1};
		err_add = 1'b0; err_pos = len_q[CA_W-1:0];
		q_we = 1'b0;
		cmd_we = 1'b0; cmd_waddr = len_q[CA_W-1:0]; cmd_wdata = item.code;
		jmp_we = 1'b0; jmp_waddr = at_q; jmp_wdata = stk_rdata;
		tape_we = 1'b0; tape_waddr = dp_q; tape_wdata = 8'd0;
		stk_we = 1'b0; stk_waddr = sh_q[SA_W-1:0]; stk_wdata = len_q[CA_W-1:0];
		stk_raddr = SA_W'(sh_q - 1'b1);
		err_we = 1'b0; err_waddr = ec_q[EA_W-1:0]; err_raddr = ei_q[EA_W-1:0];

		case (state_q)
			blm_pkg::S_CLR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				clr_d      = clr_q + 1'b1;
			end
			blm_pkg::S_IDLE: begin
				if (go) begin
					emit = 1'b1;
					case (item.kind)
						blm_pkg::KIND_LOAD: begin
							if (load_ok) begin
								cmd_we = 1'b1;
								len_d  = len_q + 1'b1;
								if (item.code == blm_pkg::CMD_OPEN) begin
									if (sh_q < SH_W'(blm_pkg::STACK_DEPTH)) begin
										stk_we = 1'b1;
										sh_d   = sh_q + 1'b1;
									end else begin
										err_add = 1'b1;
									end
								end else if (item.code == blm_pkg::CMD_CLOSE) begin
									if (sh_q == '0) begin
										err_add = 1'b1;
									end else begin
										sh_d = sh_q - 1'b1;
										at_d = len_q[CA_W-1:0];
									end
								end
							end
						end
						blm_pkg::KIND_FINISH: begin
							emit = 1'b0;
							fi_d = '0;
						end
						blm_pkg::KIND_QUEUE: begin
							if (qc_q == QC_W'(blm_pkg::INPUT_DEPTH)) begin
								res_d.status = blm_pkg::STAT_OVF;
							end else begin
								q_we = 1'b1;
								qc_d = qc_q + 1'b1;
							end
						end
						blm_pkg::KIND_STEP: begin
							if (ec_q != '0 || sh_q != '0) begin
								res_d.status = blm_pkg::STAT_REFUSE;
							end else if (!(pc_q < len_q)) begin
								res_d.status = blm_pkg::STAT_DONE;
							end else begin
								emit = 1'b0;
							end
						end
						blm_pkg::KIND_CLEAR: begin
							len_d = '0; pc_d = '0; sh_d = '0; ec_d = '0;
							dp_d = TA_W'(blm_pkg::TAPE_DEPTH / 2);
							qh_d = '0; qc_d = '0; ended_d = 1'b0; clr_d = '0;
						end
						default: res_d.status = blm_pkg::STAT_REFUSE;
					endcase
				end
			end
			blm_pkg::S_LDJ_RD: begin
				// pair the closing bracket with the popped opening one
				jmp_we = 1'b1;
				open_d = stk_rdata;
			end
			blm_pkg::S_LDJ_W2: begin
				jmp_we    = 1'b1;
				jmp_waddr = open_q;
				jmp_wdata = at_q;
			end
			blm_pkg::S_FIN_RD: begin
				stk_raddr = fi_q[SA_W-1:0];
				if (fi_q == sh_q) begin
					sh_d = '0;
					ei_d = '0;
				end
			end
			blm_pkg::S_FIN_WR: begin
				stk_raddr = fi_q[SA_W-1:0];
				err_add   = 1'b1;
				err_pos   = stk_rdata;
				fi_d      = fi_q + 1'b1;
			end
			blm_pkg::S_FIN_ERD: begin
				if (ec_q == '0 && emit_ok) begin
					emit         = 1'b1;
					res_d.status = blm_pkg::STAT_DONE;
				end
			end
			blm_pkg::S_FIN_OUT: begin
				if (emit_ok) begin
					emit           = 1'b1;
					res_d.status   = blm_pkg::STAT_BRACKET;
					res_d.position = blm_pkg::POS_W'(err_rdata);
					res_d.last     = !ovf && (ei_q + 1'b1 == shown);
					ei_d           = ei_q + 1'b1;
				end
			end
			blm_pkg::S_FIN_OVF: begin
				if (emit_ok) begin
					emit         = 1'b1;
					res_d.status = blm_pkg::STAT_OVF;
				end
			end
			blm_pkg::S_EXEC: begin
				emit = 1'b1;
				pc_d = pc_q + 1'b1;
				case (cmd_rdata)
					blm_pkg::CMD_RIGHT: begin
						dp_d = (dp_q == TA_W'(blm_pkg::TAPE_DEPTH - 1)) ? '0 : dp_q + 1'b1;
					end
					blm_pkg::CMD_LEFT: begin
						dp_d = (dp_q == '0) ? TA_W'(blm_pkg::TAPE_DEPTH - 1) : dp_q - 1'b1;
					end
					blm_pkg::CMD_INC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata + 8'd1;
					end
					blm_pkg::CMD_DEC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata - 8'd1;
					end
					blm_pkg::CMD_OUT: begin
						res_d.status   = blm_pkg::STAT_OUTPUT;
						res_d.out_byte = tape_rdata;
					end
					blm_pkg::CMD_IN: begin
						if (!ended_q) begin
							if (qc_q == '0) begin
								// hold the counter until input arrives
								res_d.status = blm_pkg::STAT_WAIT;
								pc_d         = pc_q;
							end else begin
								qh_d = (qh_q == IQ_W'(blm_pkg::INPUT_DEPTH - 1)) ? '0 : qh_q + 1'b1;
								qc_d = qc_q - 1'b1;
								if (q_head == end_byte) begin
									ended_d = 1'b1;
								end else begin
									tape_we    = 1'b1;
									tape_wdata = q_head;
								end
							end
						end
					end
					blm_pkg::CMD_OPEN: begin
						if (tape_rdata == 8'd0) pc_d = LEN_W'(jmp_rdata) + 1'b1;
					end
					default: begin
						if (tape_rdata != 8'd0) pc_d = LEN_W'(jmp_rdata);
					end
				endcase
			end
			default: emit = 1'b0;
		endcase

		if (err_add) begin
			if (ec_q < EC_W'(blm_pkg::ERROR_DEPTH)) err_we = 1'b1;
			if (ec_q != blm_pkg::ERR_SAT) ec_d = ec_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) qmem_q[q_slot] <= item.data;
		at_q   <= at_d;
		open_q <= open_d;
		if (emit) out_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blm_pkg::S_CLR;
			len_q <= '0; pc_q <= '0; clr_q <= '0;
			dp_q <= TA_W'(blm_pkg::TAPE_DEPTH / 2);
			sh_q <= '0; fi_q <= '0; ec_q <= '0; ei_q <= '0;
			qh_q <= '0; qc_q <= '0; ended_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d; pc_q <= pc_d; clr_q <= clr_d; dp_q <= dp_d;
			sh_q <= sh_d; fi_q <= fi_d; ec_q <= ec_d; ei_q <= ei_d;
			qh_q <= qh_d; qc_q <= qc_d; ended_q <= ended_d;
			if (emit) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sh_q <= SH_W'(blm_pkg::STACK_DEPTH))
		else $error("bracket stack height beyond depth");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q <= QC_W'(blm_pkg::INPUT_DEPTH))
		else $error("input queue count beyond depth");
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == blm_pkg::S_CLR |-> !pop)
		else $error("item taken during tape clear");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> emit_ok)
		else $error("result written over an undelivered one");
	a_exec_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == blm_pkg::S_EXEC |-> pc_q < len_q)
		else $error("step executed past program end");

endmodule

// File: rtl/bracket_language_machine_top.sv
// Top level of the bracket language machine: stream ports and APB register.
// Depends on blm_pkg, blm_front, blm_back (and blm_ram through blm_back).
//
// Items arrive on the s_ stream: s_tuser holds the kind (load code byte,
// finish load, queue input byte, step, clear) and s_tdata the byte. Every
// item yields one result on the m_ stream, except finish, which yields one
// result per unmatched bracket (up to 64, the last marked overflow when
// more exist), or else one done result; m_tlast flags an item's last result.
// A step first reads the code, jump and tape memories and then executes and
// writes the cell; loads of a matched ']' go through S_LDJ_RD and S_LDJ_W2 for
// the two jump-store writes, and finish moves each stack entry through S_FIN_RD
// and S_FIN_WR and reports each error through S_FIN_ERD and S_FIN_OUT.
// A four-entry item queue sits between the front and back ends, and the
// result sits in an output register, so input keeps flowing while a result
// waits to be taken. When m_tready is low the back end holds its next
// result and the item queue fills before s_tready drops.
// After reset, and after a clear item, the tape is zeroed one cell a cycle,
// all 4096 cells, and no item is executed meanwhile. end_input_byte (read
// at address 0, written at any) resets to 10 and keeps its value over a clear.
module bracket_language_machine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [19:8] position, zero pad
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]         end_byte_q;
	logic               item_valid, pop;
	blm_pkg::blm_item_t item;
	blm_pkg::blm_res_t  res;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, end_byte_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q <= 8'd10;
		end else if (psel && penable && pwrite && pready) begin
			end_byte_q <= pwdata[7:0];
		end
	end

	blm_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_kind(s_tuser), .in_data(s_tdata),
		.item_valid, .item, .pop
	);

	blm_back u_back (
		.clk, .arst_n,
		.end_byte(end_byte_q),
		.item_valid, .item, .pop,
		.res_ready(m_tready), .res_valid(m_tvalid), .res
	);

	assign m_tdata = {4'd0, res.position, res.out_byte};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule
